// ===== rtl/core/dus_pkg.sv =====
package dus_pkg;

	// widths of fields and registers
	localparam int ARM_W      = 4;
	localparam int Q_W        = 32;
	localparam int DF_W       = 17;
	localparam int CONF_W     = 21;
	localparam int BOUND_W    = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 21;
	localparam int LN_ITER    = 16;

	// Q16.16 constants
	localparam logic [Q_W-1:0] ONE_Q = 32'h0001_0000;
	localparam logic [Q_W-1:0] LN2_Q = 32'd45426;
	localparam logic [Q_W-1:0] ERR_Q = 32'h8000_0000;

	// register reset values
	localparam logic [DF_W-1:0]    DF_RST    = 17'd64881;
	localparam logic [CONF_W-1:0]  CONF_RST  = 21'd39322;
	localparam logic [BOUND_W-1:0] BOUND_RST = 21'd65536;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONF     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUND    = 2'd2;

	// datapath commands
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
	localparam logic [OP_W-1:0] OP_RD       = 5'd2;
	localparam logic [OP_W-1:0] OP_LATCH    = 5'd3;
	localparam logic [OP_W-1:0] OP_MUL_CNT  = 5'd4;
	localparam logic [OP_W-1:0] OP_MUL_SUM  = 5'd5;
	localparam logic [OP_W-1:0] OP_WR       = 5'd6;
	localparam logic [OP_W-1:0] OP_LN_INIT  = 5'd7;
	localparam logic [OP_W-1:0] OP_LN_NORM  = 5'd8;
	localparam logic [OP_W-1:0] OP_LN_MUL   = 5'd9;
	localparam logic [OP_W-1:0] OP_LN_STEP  = 5'd10;
	localparam logic [OP_W-1:0] OP_LN_FIN   = 5'd11;
	localparam logic [OP_W-1:0] OP_LN_RND   = 5'd12;
	localparam logic [OP_W-1:0] OP_CLN_MUL  = 5'd13;
	localparam logic [OP_W-1:0] OP_CLN_RND  = 5'd14;
	localparam logic [OP_W-1:0] OP_DIV_MEAN = 5'd15;
	localparam logic [OP_W-1:0] OP_DIV_EXP  = 5'd16;
	localparam logic [OP_W-1:0] OP_SQRT     = 5'd17;
	localparam logic [OP_W-1:0] OP_EXPL_MUL = 5'd18;
	localparam logic [OP_W-1:0] OP_SCORE    = 5'd19;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} dus_cmd_t;

	typedef struct packed {
		logic             div_busy;
		logic             sqrt_busy;
		logic             ln_ready;
		logic             last_arm;
		logic [ARM_W-1:0] best_arm;
	} dus_stat_t;

endpackage

// ===== rtl/core/dus_in_if.sv =====
interface dus_in_if;
	logic                      valid;
	logic                      ready;
	logic [dus_pkg::ARM_W-1:0] played_arm;
	logic                      reward_value;

	modport source (output valid, output played_arm, output reward_value, input ready);
	modport sink (input valid, input played_arm, input reward_value, output ready);
endinterface

// ===== rtl/core/dus_out_if.sv =====
interface dus_out_if;
	logic                      valid;
	logic                      ready;
	logic [dus_pkg::ARM_W-1:0] next_arm;

	modport source (output valid, output next_arm, input ready);
	modport sink (input valid, input next_arm, output ready);
endinterface

// ===== rtl/core/dus_ram.sv =====
module dus_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/core/dus_div.sv =====
// Q16.16 divide, (a << 16) / b, one quotient bit per cycle, saturated result.
module dus_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        busy,
	output logic [31:0] res
);
	logic        busy_q;
	logic        zero_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic [47:0] num_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] abs_a;
	logic [31:0] abs_b;
	logic [32:0] rem_n;
	logic        qbit;

	assign abs_a = a[31] ? (~a + 32'd1) : a;
	assign abs_b = b[31] ? (~b + 32'd1) : b;
	assign rem_n = {rem_q[31:0], num_q[47]};
	assign qbit  = (rem_n >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			zero_q <= 1'b0;
		end else if (start) begin
			zero_q <= (b == 32'd0);
			busy_q <= (b != 32'd0);
		end else if (busy_q && cnt_q == 6'd0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {abs_a, 16'd0};
			den_q <= abs_b;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= 6'd47;
			neg_q <= a[31] ^ b[31];
		end else if (busy_q) begin
			rem_q <= qbit ? (rem_n - {1'b0, den_q}) : rem_n;
			num_q <= {num_q[46:0], 1'b0};
			quo_q <= {quo_q[46:0], qbit};
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_comb begin
		if (zero_q) begin
			res = dus_pkg::ERR_Q;
		end else if (!neg_q) begin
			res = (quo_q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : quo_q[31:0];
		end else begin
			res = (quo_q > 48'h0000_8000_0000) ? 32'h8000_0000 : (~quo_q[31:0] + 32'd1);
		end
	end

	assign busy = busy_q;
endmodule

// ===== rtl/core/dus_dp.sv =====
// Datapath: arm store, shared multiplier, log and square-root sequencing, score search.
module dus_dp #(
	parameter int NUM_ARMS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dus_pkg::dus_cmd_t               cmd,
	output dus_pkg::dus_stat_t              stat,
	input  logic [dus_pkg::ARM_W-1:0]       played_arm,
	input  logic                            reward_value,
	input  logic                            cfg_we,
	input  logic [dus_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dus_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	localparam int IDXW = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
	localparam int CMPW = (IDXW > dus_pkg::ARM_W) ? IDXW : dus_pkg::ARM_W;

	function automatic logic [31:0] qround(input logic signed [67:0] p);
		logic signed [67:0] s;
		s = (p + 68'sd32768) >>> 16;
		if (s > 68'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (s < -68'sd2147483648) begin
			return 32'h8000_0000;
		end else begin
			return s[31:0];
		end
	endfunction

	logic [dus_pkg::DF_W-1:0]    df_q;
	logic [dus_pkg::CONF_W-1:0]  conf_q;
	logic [dus_pkg::BOUND_W-1:0] bound_q;

	logic [dus_pkg::ARM_W-1:0] arm_q;
	logic                      reward_q;
	logic [IDXW-1:0]           idx_q;
	logic [NUM_ARMS-1:0]       vld_q;
	logic                      vld_s1;
	logic [31:0]               ent_cnt_q;
	logic [31:0]               ent_sum_q;
	logic [31:0]               cnt_new_q;
	logic [31:0]               total_q;
	logic [63:0]               rdata;
	logic [31:0]               sum_new;
	logic                      hit;

	logic [31:0]               y_q;
	logic [4:0]                m_q;
	logic [15:0]               frac_q;
	logic                      ln_bad_q;
	logic [31:0]               ln_q;
	logic [31:0]               cln_q;
	logic [31:0]               ln_t;
	logic [15:0]               ln_int;

	logic signed [33:0]        ma;
	logic signed [33:0]        mb;
	logic signed [67:0]        p_q;
	logic [31:0]               p_rnd;

	logic                      div_start;
	logic [31:0]               div_a;
	logic [31:0]               div_res;
	logic                      div_busy;

	logic                      sq_busy_q;
	logic [47:0]               sq_v_q;
	logic [47:0]               sq_res_q;
	logic [47:0]               sq_bit_q;
	logic [47:0]               sq_sum;

	logic [31:0]               mean_q;
	logic [31:0]               score;
	logic [31:0]               best_score_q;
	logic [IDXW-1:0]           best_idx_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			df_q    <= dus_pkg::DF_RST;
			conf_q  <= dus_pkg::CONF_RST;
			bound_q <= dus_pkg::BOUND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dus_pkg::CFG_DISCOUNT: df_q    <= cfg_wdata[dus_pkg::DF_W-1:0];
				dus_pkg::CFG_CONF:     conf_q  <= cfg_wdata[dus_pkg::CONF_W-1:0];
				dus_pkg::CFG_BOUND:    bound_q <= cfg_wdata[dus_pkg::BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	dus_ram #(.WIDTH(64), .DEPTH(NUM_ARMS)) u_ram (
		.clk   (clk),
		.we    (cmd.op == dus_pkg::OP_WR),
		.waddr (idx_q),
		.wdata ({cnt_new_q, sum_new}),
		.re    (cmd.op == dus_pkg::OP_RD),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign hit     = (CMPW'(idx_q) == CMPW'(arm_q));
	assign p_rnd   = qround(p_q);
	assign sum_new = p_rnd + ((hit && reward_q) ? dus_pkg::ONE_Q : 32'd0);
	assign ln_t    = p_q[61:30];
	assign ln_int  = {11'd0, m_q} - 16'd16;
	assign score   = mean_q + p_rnd;

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			dus_pkg::OP_MUL_CNT: begin
				ma = {{2{ent_cnt_q[31]}}, ent_cnt_q};
				mb = {17'd0, df_q};
			end
			dus_pkg::OP_MUL_SUM: begin
				ma = {{2{ent_sum_q[31]}}, ent_sum_q};
				mb = {17'd0, df_q};
			end
			dus_pkg::OP_LN_MUL: begin
				ma = {2'd0, y_q};
				mb = {2'd0, y_q};
			end
			dus_pkg::OP_LN_FIN: begin
				ma = {{2{ln_int[15]}}, ln_int, frac_q};
				mb = {2'd0, dus_pkg::LN2_Q};
			end
			dus_pkg::OP_CLN_MUL: begin
				ma = {13'd0, conf_q};
				mb = {{2{ln_q[31]}}, ln_q};
			end
			dus_pkg::OP_EXPL_MUL: begin
				ma = {13'd0, bound_q};
				mb = {9'd0, sq_res_q[23:0], 1'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= ma * mb;
	end

	assign div_start = (cmd.op == dus_pkg::OP_DIV_MEAN) || (cmd.op == dus_pkg::OP_DIV_EXP);
	assign div_a     = (cmd.op == dus_pkg::OP_DIV_EXP) ? cln_q : ent_sum_q;

	dus_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (ent_cnt_q),
		.busy   (div_busy),
		.res    (div_res)
	);

	// entry valid bits: an unwritten arm reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.op == dus_pkg::OP_WR) begin
			vld_q[idx_q] <= 1'b1;
		end
	end

	// square root, one result bit per step; the bit mask moves two places per step
	assign sq_sum = sq_res_q + sq_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
		end else if (cmd.op == dus_pkg::OP_SQRT) begin
			sq_busy_q <= !div_res[31] && (div_res != 32'd0);
		end else if (sq_busy_q && sq_bit_q == 48'd1) begin
			sq_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == dus_pkg::OP_SQRT) begin
			sq_v_q   <= {div_res, 16'd0};
			sq_res_q <= '0;
			sq_bit_q <= 48'h4000_0000_0000;
		end else if (sq_busy_q) begin
			if (sq_v_q >= sq_sum) begin
				sq_v_q   <= sq_v_q - sq_sum;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			dus_pkg::OP_LOAD: begin
				arm_q        <= played_arm;
				reward_q     <= reward_value;
				idx_q        <= '0;
				total_q      <= '0;
				best_score_q <= '0;
				best_idx_q   <= '0;
			end
			dus_pkg::OP_RD: begin
				vld_s1 <= vld_q[idx_q];
			end
			dus_pkg::OP_LATCH: begin
				ent_cnt_q <= vld_s1 ? rdata[63:32] : 32'd0;
				ent_sum_q <= vld_s1 ? rdata[31:0] : 32'd0;
			end
			dus_pkg::OP_MUL_SUM: begin
				cnt_new_q <= p_rnd + (hit ? dus_pkg::ONE_Q : 32'd0);
			end
			dus_pkg::OP_WR: begin
				total_q <= total_q + cnt_new_q;
				idx_q   <= idx_q + IDXW'(1);
			end
			dus_pkg::OP_LN_INIT: begin
				y_q      <= total_q;
				m_q      <= 5'd30;
				frac_q   <= '0;
				ln_bad_q <= total_q[31] || (total_q == 32'd0);
				idx_q    <= '0;
			end
			dus_pkg::OP_LN_NORM: begin
				y_q <= {y_q[30:0], 1'b0};
				m_q <= m_q - 5'd1;
			end
			dus_pkg::OP_LN_STEP: begin
				if (ln_t[31]) begin
					y_q    <= {1'b0, ln_t[31:1]};
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					y_q    <= ln_t;
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			dus_pkg::OP_LN_RND: begin
				ln_q <= ln_bad_q ? dus_pkg::ERR_Q : p_rnd;
			end
			dus_pkg::OP_CLN_RND: begin
				cln_q <= p_rnd;
			end
			dus_pkg::OP_DIV_EXP: begin
				mean_q <= div_res;
			end
			dus_pkg::OP_SCORE: begin
				if ($signed(score) > $signed(best_score_q)) begin
					best_score_q <= score;
					best_idx_q   <= idx_q;
				end
				idx_q <= idx_q + IDXW'(1);
			end
			default: ;
		endcase
	end

	assign stat.div_busy  = div_busy;
	assign stat.sqrt_busy = sq_busy_q;
	assign stat.ln_ready  = y_q[30] || ln_bad_q;
	assign stat.last_arm  = (idx_q == IDXW'(NUM_ARMS - 1));
	assign stat.best_arm  = dus_pkg::ARM_W'(best_idx_q);
endmodule

// ===== rtl/core/dus_ctrl.sv =====
// Controller: report sequencing, step counter and result register.
module dus_ctrl #(
	parameter int NUM_ARMS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [dus_pkg::ARM_W-1:0] next_arm,
	output dus_pkg::dus_cmd_t         cmd,
	input  dus_pkg::dus_stat_t        stat
);
	localparam int SCW = $clog2(NUM_ARMS + 2);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_A_RD   = 5'd1;
	localparam logic [4:0] S_A_LAT  = 5'd2;
	localparam logic [4:0] S_A_MC   = 5'd3;
	localparam logic [4:0] S_A_MS   = 5'd4;
	localparam logic [4:0] S_A_WR   = 5'd5;
	localparam logic [4:0] S_L_INIT = 5'd6;
	localparam logic [4:0] S_L_NORM = 5'd7;
	localparam logic [4:0] S_L_SQ   = 5'd8;
	localparam logic [4:0] S_L_STEP = 5'd9;
	localparam logic [4:0] S_L_FIN  = 5'd10;
	localparam logic [4:0] S_L_RND  = 5'd11;
	localparam logic [4:0] S_C_MUL  = 5'd12;
	localparam logic [4:0] S_C_RND  = 5'd13;
	localparam logic [4:0] S_B_RD   = 5'd14;
	localparam logic [4:0] S_B_LAT  = 5'd15;
	localparam logic [4:0] S_B_D1   = 5'd16;
	localparam logic [4:0] S_B_W1   = 5'd17;
	localparam logic [4:0] S_B_W2   = 5'd18;
	localparam logic [4:0] S_B_W3   = 5'd19;
	localparam logic [4:0] S_B_SC   = 5'd20;
	localparam logic [4:0] S_FIN    = 5'd21;

	logic [4:0]                state_q;
	logic [4:0]                state_d;
	logic [SCW-1:0]            sc_q;
	logic [SCW-1:0]            sc_next;
	logic [3:0]                it_q;
	logic                      use_step_q;
	logic [dus_pkg::ARM_W-1:0] pick_q;
	logic                      out_valid_q;
	logic [dus_pkg::ARM_W-1:0] next_arm_q;
	logic                      in_acc;
	logic                      out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign sc_next  = (sc_q < SCW'(NUM_ARMS + 1)) ? (sc_q + SCW'(1)) : sc_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = dus_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd.op  = dus_pkg::OP_LOAD;
					state_d = S_A_RD;
				end
			end
			S_A_RD: begin
				cmd.op  = dus_pkg::OP_RD;
				state_d = S_A_LAT;
			end
			S_A_LAT: begin
				cmd.op  = dus_pkg::OP_LATCH;
				state_d = S_A_MC;
			end
			S_A_MC: begin
				cmd.op  = dus_pkg::OP_MUL_CNT;
				state_d = S_A_MS;
			end
			S_A_MS: begin
				cmd.op  = dus_pkg::OP_MUL_SUM;
				state_d = S_A_WR;
			end
			S_A_WR: begin
				cmd.op = dus_pkg::OP_WR;
				if (!stat.last_arm) begin
					state_d = S_A_RD;
				end else if (use_step_q) begin
					state_d = S_FIN;
				end else begin
					state_d = S_L_INIT;
				end
			end
			S_L_INIT: begin
				cmd.op  = dus_pkg::OP_LN_INIT;
				state_d = S_L_NORM;
			end
			S_L_NORM: begin
				if (stat.ln_ready) begin
					state_d = S_L_SQ;
				end else begin
					cmd.op = dus_pkg::OP_LN_NORM;
				end
			end
			S_L_SQ: begin
				cmd.op  = dus_pkg::OP_LN_MUL;
				state_d = S_L_STEP;
			end
			S_L_STEP: begin
				cmd.op  = dus_pkg::OP_LN_STEP;
				state_d = (it_q == 4'(dus_pkg::LN_ITER - 1)) ? S_L_FIN : S_L_SQ;
			end
			S_L_FIN: begin
				cmd.op  = dus_pkg::OP_LN_FIN;
				state_d = S_L_RND;
			end
			S_L_RND: begin
				cmd.op  = dus_pkg::OP_LN_RND;
				state_d = S_C_MUL;
			end
			S_C_MUL: begin
				cmd.op  = dus_pkg::OP_CLN_MUL;
				state_d = S_C_RND;
			end
			S_C_RND: begin
				cmd.op  = dus_pkg::OP_CLN_RND;
				state_d = S_B_RD;
			end
			S_B_RD: begin
				cmd.op  = dus_pkg::OP_RD;
				state_d = S_B_LAT;
			end
			S_B_LAT: begin
				cmd.op  = dus_pkg::OP_LATCH;
				state_d = S_B_D1;
			end
			S_B_D1: begin
				cmd.op  = dus_pkg::OP_DIV_MEAN;
				state_d = S_B_W1;
			end
			S_B_W1: begin
				if (!stat.div_busy) begin
					cmd.op  = dus_pkg::OP_DIV_EXP;
					state_d = S_B_W2;
				end
			end
			S_B_W2: begin
				if (!stat.div_busy) begin
					cmd.op  = dus_pkg::OP_SQRT;
					state_d = S_B_W3;
				end
			end
			S_B_W3: begin
				if (!stat.sqrt_busy) begin
					cmd.op  = dus_pkg::OP_EXPL_MUL;
					state_d = S_B_SC;
				end
			end
			S_B_SC: begin
				cmd.op  = dus_pkg::OP_SCORE;
				state_d = stat.last_arm ? S_FIN : S_B_RD;
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sc_q        <= SCW'(1);
			it_q        <= '0;
			use_step_q  <= 1'b0;
			pick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				sc_q       <= sc_next;
				use_step_q <= (sc_next - SCW'(1)) < SCW'(NUM_ARMS);
				pick_q     <= dus_pkg::ARM_W'(sc_next - SCW'(1));
			end
			if (state_q == S_L_INIT) begin
				it_q <= '0;
			end else if (state_q == S_L_STEP) begin
				it_q <= it_q + 4'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			next_arm_q <= use_step_q ? pick_q : stat.best_arm;
		end
	end

	assign out_valid = out_valid_q;
	assign next_arm  = next_arm_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_A_RD)
		else $error("report accepted but update pass not started");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sc_q >= SCW'(1)) && (sc_q <= SCW'(NUM_ARMS + 1)))
		else $error("step counter out of range");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result loaded outside final state");

	a_div_idle_at_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_B_W3 |-> !stat.div_busy)
		else $error("divider busy while square root runs");
endmodule

// ===== rtl/core/discounted_ucb_arm_selector_top.sv =====
// Discounted UCB arm selector. Each request on the report channel names the
// arm just played and its 0/1 reward; the block decays every arm's count and
// reward sum by discount_factor (Q1.16), credits the played arm, and returns
// one next_arm on the choice channel. During the first NUM_ARMS-1 reports the
// answer is the report number; afterwards it is the lowest arm with the
// largest positive score mean + 2*bound*sqrt(conf*ln(total)/count), arm 0 if
// no score is positive. One request is worked at a time. The update pass
// walks the arms one by one through the arm store; the selection pass adds
// the log (normalising shift, set by the size of the total, plus 16
// squarings on the shared multiplier) and, for each arm, the bit-serial
// divider run twice and the 24-step square root. A finished result waits in
// an output register, so the next report is taken while it is unread. The
// user must write registers through cfg_we/cfg_index/cfg_wdata (0 discount,
// 1 confidence scale, 2 reward bound) only while idle; the block itself does
// not enforce this.
module discounted_ucb_arm_selector_top #(
	parameter int NUM_ARMS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dus_in_if.sink                         report,
	dus_out_if.source                      choice,
	input  logic                           cfg_we,
	input  logic [dus_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dus_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	dus_pkg::dus_cmd_t  cmd;
	dus_pkg::dus_stat_t stat;

	// sequencing, step count and result register
	dus_ctrl #(.NUM_ARMS(NUM_ARMS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (report.valid),
		.in_ready  (report.ready),
		.out_valid (choice.valid),
		.out_ready (choice.ready),
		.next_arm  (choice.next_arm),
		.cmd       (cmd),
		.stat      (stat)
	);

	// arm store, arithmetic units and configuration registers
	dus_dp #(.NUM_ARMS(NUM_ARMS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.played_arm   (report.played_arm),
		.reward_value (report.reward_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);
endmodule
